[rtl/mibe_pkg.sv]
package mibe_pkg;

  typedef enum logic [5:0] {
    OP_REGIMM        = 6'd1,
    OP_J             = 6'd2,
    OP_JAL           = 6'd3,
    OP_BEQ           = 6'd4,
    OP_BNE           = 6'd5,
    OP_BLEZ          = 6'd6,
    OP_BGTZ          = 6'd7,
    OP_ADDI          = 6'd8,
    OP_ADDI_NOTRAP   = 6'd9,
    OP_SLTI          = 6'd10,
    OP_SLTI_UNSIGNED = 6'd11,
    OP_ANDI          = 6'd12,
    OP_ORI           = 6'd13,
    OP_XORI          = 6'd14,
    OP_LUI           = 6'd15,
    OP_BEQL          = 6'd20,
    OP_BNEL          = 6'd21,
    OP_BLEZ_LIKELY   = 6'd22,
    OP_BGTZ_LIKELY   = 6'd23
  } opcode_e;

  // REGIMM condition bits in rt
  localparam int unsigned RegimmInvBit    = 0;
  localparam int unsigned RegimmLikelyBit = 1;
  localparam int unsigned RegimmLinkBit   = 4;

  localparam logic [4:0]  LinkReg     = 5'd31;
  localparam logic [31:0] JumpRegion  = 32'hf000_0000;
  localparam logic [31:0] InstrBytes  = 32'd4;
  localparam logic [31:0] LinkOffset  = 32'd8;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [4:0]  rt_field;
    logic [15:0] immediate;
    logic [25:0] jump_index;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [31:0] pc;
  } exec_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic        redirect;
    logic [31:0] next_pc;
    logic        nullify_next;
    logic        overflow_trap;
    logic        illegal;
  } exec_out_t;

endpackage

[rtl/mibe_exec.sv]
module mibe_exec (
  input  mibe_pkg::exec_in_t  instr_i,
  output mibe_pkg::exec_out_t result_o
);

  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] btarget;
  logic [31:0] jtarget;
  logic [31:0] link;
  logic [31:0] sum;
  logic        add_ovf;
  logic        is_branch;
  logic        taken;
  logic        likely;
  logic        rs_zero;
  logic        rs_neg;

  assign simm    = {{16{instr_i.immediate[15]}}, instr_i.immediate};
  assign zimm    = {16'd0, instr_i.immediate};
  assign btarget = instr_i.pc + mibe_pkg::InstrBytes
                   + {{14{instr_i.immediate[15]}}, instr_i.immediate, 2'b00};
  assign jtarget = (instr_i.pc & mibe_pkg::JumpRegion) | {4'd0, instr_i.jump_index, 2'b00};
  assign link    = instr_i.pc + mibe_pkg::LinkOffset;
  assign sum     = instr_i.rs_value + simm;
  // same-sign operands, result sign flipped
  assign add_ovf = (instr_i.rs_value[31] == simm[31]) && (sum[31] != instr_i.rs_value[31]);
  assign rs_zero = (instr_i.rs_value == 32'd0);
  assign rs_neg  = instr_i.rs_value[31];

  always_comb begin
    result_o  = '0;
    is_branch = 1'b0;
    taken     = 1'b0;
    likely    = 1'b0;
    unique case (instr_i.opcode) inside
      mibe_pkg::OP_REGIMM: begin
        is_branch = 1'b1;
        taken     = rs_neg ^ instr_i.rt_field[mibe_pkg::RegimmInvBit];
        likely    = instr_i.rt_field[mibe_pkg::RegimmLikelyBit];
        if (instr_i.rt_field[mibe_pkg::RegimmLinkBit]) begin
          result_o.write_enable = 1'b1;
          result_o.write_index  = mibe_pkg::LinkReg;
          result_o.write_value  = link;
        end
      end
      mibe_pkg::OP_J: begin
        result_o.redirect = 1'b1;
        result_o.next_pc  = jtarget;
      end
      mibe_pkg::OP_JAL: begin
        result_o.redirect     = 1'b1;
        result_o.next_pc      = jtarget;
        result_o.write_enable = 1'b1;
        result_o.write_index  = mibe_pkg::LinkReg;
        result_o.write_value  = link;
      end
      mibe_pkg::OP_BEQ, mibe_pkg::OP_BEQL: begin
        is_branch = 1'b1;
        taken     = (instr_i.rs_value == instr_i.rt_value);
        likely    = (instr_i.opcode == mibe_pkg::OP_BEQL);
      end
      mibe_pkg::OP_BNE, mibe_pkg::OP_BNEL: begin
        is_branch = 1'b1;
        taken     = (instr_i.rs_value != instr_i.rt_value);
        likely    = (instr_i.opcode == mibe_pkg::OP_BNEL);
      end
      mibe_pkg::OP_BLEZ, mibe_pkg::OP_BLEZ_LIKELY: begin
        is_branch = 1'b1;
        taken     = rs_neg || rs_zero;
        likely    = (instr_i.opcode == mibe_pkg::OP_BLEZ_LIKELY);
      end
      mibe_pkg::OP_BGTZ, mibe_pkg::OP_BGTZ_LIKELY: begin
        is_branch = 1'b1;
        taken     = !rs_neg && !rs_zero;
        likely    = (instr_i.opcode == mibe_pkg::OP_BGTZ_LIKELY);
      end
      mibe_pkg::OP_ADDI: begin
        if (add_ovf) begin
          result_o.overflow_trap = 1'b1;
        end else begin
          result_o.write_enable = 1'b1;
          result_o.write_index  = instr_i.rt_field;
          result_o.write_value  = sum;
        end
      end
      mibe_pkg::OP_ADDI_NOTRAP: begin
        result_o.write_enable = 1'b1;
        result_o.write_index  = instr_i.rt_field;
        result_o.write_value  = sum;
      end
      mibe_pkg::OP_SLTI: begin
        result_o.write_enable = 1'b1;
        result_o.write_index  = instr_i.rt_field;
        result_o.write_value  = {31'd0, ($signed(instr_i.rs_value) < $signed(simm))};
      end
      mibe_pkg::OP_SLTI_UNSIGNED: begin
        result_o.write_enable = 1'b1;
        result_o.write_index  = instr_i.rt_field;
        result_o.write_value  = {31'd0, (instr_i.rs_value < simm)};
      end
      mibe_pkg::OP_ANDI: begin
        result_o.write_enable = 1'b1;
        result_o.write_index  = instr_i.rt_field;
        result_o.write_value  = instr_i.rs_value & zimm;
      end
      mibe_pkg::OP_ORI: begin
        result_o.write_enable = 1'b1;
        result_o.write_index  = instr_i.rt_field;
        result_o.write_value  = instr_i.rs_value | zimm;
      end
      mibe_pkg::OP_XORI: begin
        result_o.write_enable = 1'b1;
        result_o.write_index  = instr_i.rt_field;
        result_o.write_value  = instr_i.rs_value ^ zimm;
      end
      mibe_pkg::OP_LUI: begin
        result_o.write_enable = 1'b1;
        result_o.write_index  = instr_i.rt_field;
        result_o.write_value  = {instr_i.immediate, 16'd0};
      end
      default: begin
        result_o.illegal = 1'b1;
      end
    endcase

    if (is_branch) begin
      if (taken) begin
        result_o.redirect = 1'b1;
        result_o.next_pc  = btarget;
      end else if (likely) begin
        result_o.nullify_next = 1'b1;
      end
    end
  end

endmodule

[rtl/mips_itype_branch_execute.sv]
// Execute stage for MIPS32 immediate-format ALU ops, branches and jumps. One instruction
// beat is accepted every cycle unless the input side is stalled; an accepted beat waits in
// the input register while the decode, 32-bit adders and compares settle, then moves into
// the result register, which presents it on the outputs. A stall on the result side holds
// the result register and, when the input register is also full, stalls the input side in
// the same cycle.
module mips_itype_branch_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  opcode_i,
  input  logic [4:0]  rt_field_i,
  input  logic [15:0] immediate_i,
  input  logic [25:0] jump_index_i,
  input  logic [31:0] rs_value_i,
  input  logic [31:0] rt_value_i,
  input  logic [31:0] pc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [4:0]  write_index_o,
  output logic [31:0] write_value_o,
  output logic        redirect_o,
  output logic [31:0] next_pc_o,
  output logic        nullify_next_o,
  output logic        overflow_trap_o,
  output logic        illegal_o
);

  mibe_pkg::exec_in_t  instr_q;
  mibe_pkg::exec_out_t exec_res;
  mibe_pkg::exec_out_t res_q;
  logic                in_vld_q;
  logic                out_vld_q;
  logic                out_adv;
  logic                in_take;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      instr_q.opcode     <= opcode_i;
      instr_q.rt_field   <= rt_field_i;
      instr_q.immediate  <= immediate_i;
      instr_q.jump_index <= jump_index_i;
      instr_q.rs_value   <= rs_value_i;
      instr_q.rt_value   <= rt_value_i;
      instr_q.pc         <= pc_i;
    end
    if (out_adv && in_vld_q) begin
      res_q <= exec_res;
    end
  end

  mibe_exec u_exec (
    .instr_i  (instr_q),
    .result_o (exec_res)
  );

  assign out_valid_o     = out_vld_q;
  assign write_enable_o  = res_q.write_enable;
  assign write_index_o   = res_q.write_index;
  assign write_value_o   = res_q.write_value;
  assign redirect_o      = res_q.redirect;
  assign next_pc_o       = res_q.next_pc;
  assign nullify_next_o  = res_q.nullify_next;
  assign overflow_trap_o = res_q.overflow_trap;
  assign illegal_o       = res_q.illegal;

`ifndef NO_ASSERTIONS
  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_adv |=> out_vld_q)
    else $error("filled input register did not move to result register");

  a_no_redirect_zero_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !redirect_o |-> next_pc_o == 32'd0)
    else $error("next_pc nonzero without redirect");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> write_index_o == 5'd0 && write_value_o == 32'd0)
    else $error("write fields nonzero without write");

  a_illegal_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && illegal_o |->
      !write_enable_o && !redirect_o && !nullify_next_o && !overflow_trap_o)
    else $error("illegal result carries other effects");

  a_trap_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_trap_o |-> !write_enable_o && !redirect_o)
    else $error("overflow trap with write or redirect");
`endif

endmodule
